>>> hw/rtl/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg
// shared types and constants for the sorted record insert table
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int unsigned DefaultDepth = 256;
    localparam int unsigned CodeW        = 16;
    localparam int unsigned DateW        = 27;
    localparam int unsigned QtyW         = 16;
    localparam int unsigned SlotW        = 8;
    localparam int unsigned CountW       = 9;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic [DateW-1:0] date;
        logic [QtyW-1:0]  qty;
    } rec_t;

    // what one cell shows its upper neighbor
    typedef struct packed {
        logic valid;
        logic take;
        rec_t rec;
    } link_t;

endpackage

>>> hw/rtl/srit_cell.sv
// ----------------------------------------------------------------------------
// srit_cell
// one table slot: holds a record, compares against the new key, shifts up
// ----------------------------------------------------------------------------
module srit_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ins,
    input  srit_pkg::rec_t  new_rec,
    input  srit_pkg::link_t prev,
    output srit_pkg::link_t self,
    output logic          landing
);
    import srit_pkg::*;

    logic valid_reg;
    rec_t rec_reg;
    logic take;

    // slot is free or holds a larger key: new record lands here or below
    assign take    = !valid_reg || (rec_reg.qty > new_rec.qty);
    assign landing = take && !prev.take;

    assign self.valid = valid_reg;
    assign self.take  = take;
    assign self.rec   = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ins)
        begin
            if (prev.take)
            begin
                valid_reg <= prev.valid;
            end
            else if (take)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            if (prev.take)
            begin
                rec_reg <= prev.rec;
            end
            else if (take)
            begin
                rec_reg <= new_rec;
            end
        end
    end

endmodule

>>> hw/rtl/srit_slot_enc.sv
// ----------------------------------------------------------------------------
// srit_slot_enc
// registered one-hot to index encoder for the landing slot
// ----------------------------------------------------------------------------
module srit_slot_enc
#(
    parameter int unsigned DEPTH = srit_pkg::DefaultDepth
)
(
    input  logic                       clk,
    input  logic                       load,
    input  logic [DEPTH-1:0]           onehot,
    output logic [$clog2(DEPTH)-1:0]   slot
);
    import srit_pkg::*;

    localparam int unsigned IdxW = $clog2(DEPTH);

    logic [IdxW-1:0] slot_next;
    logic [IdxW-1:0] slot_reg;

    always_comb
    begin
        slot_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (onehot[i])
            begin
                slot_next = slot_next | IdxW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

>>> hw/rtl/sorted_record_insert_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_record_insert_table_unit
// table of records kept sorted ascending by unit quantity
// ----------------------------------------------------------------------------
// usage:
//   input channel carries product_code, expiry_date, unit_quantity with
//   in_valid / in_stall; output channel carries insert_slot, entry_count,
//   table_full with out_valid / out_stall
//   every input transaction yields exactly one output transaction
//   a record lands after all held entries with quantity <= its own, larger
//   entries move up one slot; a full table drops the record and flags it
//   the result is offered from the output stage, after the middle stage
//   throughput: one transaction per cycle while in_stall is low; the chain
//   of slot cells updates on acceptance, the slot index is encoded in the following stage
//   reset empties the table (count zero, all slot valid bits cleared) and
//   leaves the output channel empty; no clearing pass is needed
//   when the receiver stalls the result holds steady; one more transaction
//   waits in the middle stage, after that in_stall rises until the
//   receiver takes the result
// ----------------------------------------------------------------------------
module sorted_record_insert_table_unit
#(
    parameter int unsigned TABLE_DEPTH = srit_pkg::DefaultDepth
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [srit_pkg::CodeW-1:0]    product_code,
    input  logic [srit_pkg::DateW-1:0]    expiry_date,
    input  logic [srit_pkg::QtyW-1:0]     unit_quantity,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [srit_pkg::SlotW-1:0]    insert_slot,
    output logic [srit_pkg::CountW-1:0]   entry_count,
    output logic                          table_full
);
    import srit_pkg::*;

    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

    // occupancy
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            full;

    // handshake
    logic in_fire;
    logic ins;
    logic out_free;
    logic s1_move;

    // middle stage: landing vector waiting for encoding
    logic                   s1_valid_reg;
    logic [TABLE_DEPTH-1:0] s1_land_reg;
    logic                   s1_full_reg;
    logic [CntW-1:0]        s1_count_reg;

    // output stage
    logic            out_valid_reg;
    logic            out_full_reg;
    logic [CntW-1:0] out_count_reg;
    logic [IdxW-1:0] slot_q;

    // cell chain
    rec_t                   new_rec;
    link_t                  links [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] landing;
    link_t                  bottom;

    assign full     = (count_reg == CntW'(TABLE_DEPTH));
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;
    assign ins      = in_fire && !full;

    assign new_rec.code = product_code;
    assign new_rec.date = expiry_date;
    assign new_rec.qty  = unit_quantity;

    // below slot zero nothing shifts in
    assign bottom.valid = 1'b0;
    assign bottom.take  = 1'b0;
    assign bottom.rec   = new_rec;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        srit_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ins     (ins),
            .new_rec (new_rec),
            .prev    ((g == 0) ? bottom : links[(g == 0) ? 0 : g - 1]),
            .self    (links[g]),
            .landing (landing[g])
        );
    end

    assign count_next = ins ? (count_reg + CntW'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            // a dropped record lands nowhere, so the encoded slot reads zero
            s1_land_reg  <= full ? '0 : landing;
            s1_full_reg  <= full;
            s1_count_reg <= count_next;
        end
        if (s1_move)
        begin
            out_full_reg  <= s1_full_reg;
            out_count_reg <= s1_count_reg;
        end
    end

    srit_slot_enc #(.DEPTH(TABLE_DEPTH)) u_slot_enc
    (
        .clk    (clk),
        .load   (s1_move),
        .onehot (s1_land_reg),
        .slot   (slot_q)
    );

    assign out_valid   = out_valid_reg;
    assign insert_slot = SlotW'(slot_q);
    assign entry_count = CountW'(out_count_reg);
    assign table_full  = out_full_reg;

endmodule
